// ===== design/plst_pkg.sv =====
`default_nettype none

package plst_pkg;

  // fixed field widths of the item and result beats
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;
  localparam int RADIUS_W = 15;
  localparam int CNT_W    = 7;

  // operation codes carried in kind
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 3'd0,
    KIND_POP    = 3'd1,
    KIND_REMOVE = 3'd2,
    KIND_COUNT  = 3'd3,
    KIND_RANGE  = 3'd4
  } kind_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_NOMATCH = 2'd3
  } status_t;

endpackage

`default_nettype wire

// ===== design/plst_ram.sv =====
`default_nettype none

module plst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/point_list_store_with_radius_query_top.sv =====
`default_nettype none

// flow: insert, remove newest, unused kinds and items on an empty list go straight to the finish
//   state, which loads their single result; scans do one ram read (load) and one compare (eval)
//   per stored point walked, and a middle removal adds one shift step per point moved down
// throughput: one item at a time; the next item beat is taken once the last result is loaded
// reset: rst clears the point count and all handshake state; the point ram is not cleared,
//   since only entries below the count are ever used
module point_list_store_with_radius_query_top
  import plst_pkg::*;
#(
  parameter int DEPTH      = 64,
  parameter int COORD_BITS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // item channel
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [KIND_W-1:0]     kind,
  input  wire logic [COORD_BITS-1:0] x_coord,
  input  wire logic [COORD_BITS-1:0] y_coord,
  input  wire logic [RADIUS_W-1:0]   radius,
  // result channel
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [STATUS_W-1:0]        status,
  output logic                       point_valid,
  output logic [COORD_BITS-1:0]      out_x,
  output logic [COORD_BITS-1:0]      out_y,
  output logic [CNT_W-1:0]           match_count,
  output logic [CNT_W-1:0]           occupancy,
  output logic                       last
);

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int CB    = COORD_BITS;
  localparam int SQ_W  = 2 * CB;
  localparam int LIM_W = 2 * RADIUS_W;
  localparam int CMP_W = (SQ_W + 1 > LIM_W) ? SQ_W + 1 : LIM_W;

  // the ram holds points oldest first: physical entry count-1 is the newest point,
  // so logical order (newest first) is a walk from count-1 down to 0
  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_EVAL,
    S_SHIFT,
    S_TAIL,
    S_FINISH
  } state_t;

  state_t              state;
  logic [CW-1:0]       count;
  logic [AW-1:0]       idx;
  logic [KIND_W-1:0]   kind_r;
  logic [CB-1:0]       key_x;
  logic [CB-1:0]       key_y;
  logic [RADIUS_W-1:0] rad_r;
  logic [CB-1:0]       pt_x;
  logic [CB-1:0]       pt_y;
  logic [SQ_W-1:0]     sq_x;
  logic [SQ_W-1:0]     sq_y;
  logic [LIM_W-1:0]    lim;
  logic [CW-1:0]       hits;
  status_t             res_status;

  // one range-query hit held back so the final one can carry last
  logic                pend_valid;
  logic [CB-1:0]       pend_x;
  logic [CB-1:0]       pend_y;

  // ram ports
  logic                ram_we;
  logic [AW-1:0]       ram_waddr;
  logic [2*CB-1:0]     ram_wdata;
  logic [AW-1:0]       ram_raddr;
  logic [2*CB-1:0]     ram_rdata;

  logic                accept;
  logic                out_free;
  logic                is_full;
  logic                is_empty;
  logic [AW-1:0]       top_addr;
  logic                is_match;
  logic                in_range;
  logic                rm_hit;
  logic                scan_end;
  logic                eval_stall;
  logic [CB-1:0]       mag_x;
  logic [CB-1:0]       mag_y;
  logic [SQ_W-1:0]     sq_x_c;
  logic [SQ_W-1:0]     sq_y_c;

  function automatic logic [CB-1:0] mag(input logic [CB-1:0] v);
    mag = v[CB-1] ? ((~v) + CB'(1)) : v;
  endfunction

  plst_ram #(
    .WIDTH (2 * CB),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  // result register may be reloaded when empty or drained this cycle
  assign out_free = !out_valid || out_ready;
  assign is_full  = (count == CW'(DEPTH));
  assign is_empty = (count == '0);
  assign top_addr = AW'(count - CW'(1));

  // squares of the point just read, registered before the compare
  assign mag_x  = mag(ram_rdata[2*CB-1:CB]);
  assign mag_y  = mag(ram_rdata[CB-1:0]);
  assign sq_x_c = SQ_W'(mag_x) * SQ_W'(mag_x);
  assign sq_y_c = SQ_W'(mag_y) * SQ_W'(mag_y);

  assign is_match   = (pt_x == key_x) && (pt_y == key_y);
  assign in_range   = (CMP_W'(sq_x) + CMP_W'(sq_y)) <= CMP_W'(lim);
  assign rm_hit     = (kind_r == KIND_REMOVE) && is_match;
  assign scan_end   = (idx == '0);
  // a second hit needs the result register to pass on the held one
  assign eval_stall = (kind_r == KIND_RANGE) && in_range && pend_valid && !out_free;

  // ram access; reads are free of side effects so the read address only matters
  // where a later state uses the data
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(count);
    ram_wdata = {x_coord, y_coord};
    ram_raddr = top_addr;
    unique case (state)
      S_IDLE: begin
        // insert lands directly above the current newest point
        ram_we = accept && (kind == KIND_INSERT) && !is_full;
      end
      S_EVAL: begin
        ram_raddr = rm_hit ? (idx + AW'(1)) : (idx - AW'(1));
      end
      S_SHIFT: begin
        // move the entry read last cycle one place down, fetch the next one
        ram_we    = 1'b1;
        ram_waddr = idx - AW'(1);
        ram_wdata = ram_rdata;
        ram_raddr = idx + AW'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            kind_r     <= kind;
            key_x      <= x_coord;
            key_y      <= y_coord;
            rad_r      <= radius;
            hits       <= '0;
            pend_valid <= 1'b0;
            idx        <= top_addr;
            res_status <= ST_OK;
            state      <= S_FINISH;
            unique case (kind)
              KIND_INSERT: begin
                if (is_full) begin
                  res_status <= ST_FULL;
                end else begin
                  count <= count + CW'(1);
                end
              end
              KIND_POP: begin
                if (is_empty) begin
                  res_status <= ST_EMPTY;
                end else begin
                  count <= count - CW'(1);
                end
              end
              KIND_REMOVE, KIND_RANGE: begin
                if (is_empty) begin
                  res_status <= ST_EMPTY;
                end else begin
                  state <= S_LOAD;
                end
              end
              KIND_COUNT: begin
                if (!is_empty) begin
                  state <= S_LOAD;
                end
              end
              default: begin
              end
            endcase
          end
        end

        S_LOAD: begin
          pt_x  <= ram_rdata[2*CB-1:CB];
          pt_y  <= ram_rdata[CB-1:0];
          sq_x  <= sq_x_c;
          sq_y  <= sq_y_c;
          lim   <= LIM_W'(rad_r) * LIM_W'(rad_r);
          state <= S_EVAL;
        end

        S_EVAL: begin
          if (!eval_stall) begin
            if ((kind_r == KIND_COUNT) && is_match) begin
              hits <= hits + CW'(1);
            end
            if ((kind_r == KIND_RANGE) && in_range) begin
              pend_valid <= 1'b1;
              pend_x     <= pt_x;
              pend_y     <= pt_y;
              if (pend_valid) begin
                out_valid   <= 1'b1;
                status      <= ST_OK;
                point_valid <= 1'b1;
                out_x       <= pend_x;
                out_y       <= pend_y;
                match_count <= '0;
                occupancy   <= CNT_W'(count);
                last        <= 1'b0;
              end
            end

            if (rm_hit) begin
              if (idx == top_addr) begin
                // newest-end match: nothing to compact
                count      <= count - CW'(1);
                res_status <= ST_OK;
                state      <= S_FINISH;
              end else begin
                idx   <= idx + AW'(1);
                state <= S_SHIFT;
              end
            end else if (scan_end) begin
              res_status <= (kind_r == KIND_REMOVE) ? ST_NOMATCH : ST_OK;
              state      <= (kind_r == KIND_RANGE) ? S_TAIL : S_FINISH;
            end else begin
              idx   <= idx - AW'(1);
              state <= S_LOAD;
            end
          end
        end

        S_SHIFT: begin
          if (idx == top_addr) begin
            count      <= count - CW'(1);
            res_status <= ST_OK;
            state      <= S_FINISH;
          end else begin
            idx <= idx + AW'(1);
          end
        end

        S_TAIL: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            status      <= pend_valid ? ST_OK : ST_NOMATCH;
            point_valid <= pend_valid;
            out_x       <= pend_valid ? pend_x : '0;
            out_y       <= pend_valid ? pend_y : '0;
            match_count <= '0;
            occupancy   <= CNT_W'(count);
            last        <= 1'b1;
            pend_valid  <= 1'b0;
            state       <= S_IDLE;
          end
        end

        S_FINISH: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            point_valid <= 1'b0;
            out_x       <= '0;
            out_y       <= '0;
            match_count <= CNT_W'(hits);
            occupancy   <= CNT_W'(count);
            last        <= 1'b1;
            state       <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // point count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("point count above depth");

  // a held-back hit only exists while a range query runs
  a_pend_range: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (kind_r == KIND_RANGE) && (state != S_IDLE) && (state != S_FINISH))
    else $error("held hit outside range query");

  // compaction only moves entries that lie above the removed one and below the count
  a_shift_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT) |-> (idx != '0) && (idx <= top_addr) && !is_empty)
    else $error("compaction index out of range");

  // a result beat loaded while scanning is never the final one
  a_mid_not_last: assert property (@(posedge clk) disable iff (rst)
    ($past(state) == S_EVAL) && $rose(out_valid) |-> !last && point_valid)
    else $error("mid-scan beat marked last");

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top
  import plst_pkg::*;
();

  localparam int DEPTH      = 64;
  localparam int COORD_BITS = 16;
  // kinds above the range query carry no operation
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;
  localparam logic [RADIUS_W-1:0] RADIUS_MAX  = 15'h7fff;
  localparam logic [COORD_BITS-1:0] COORD_MIN = 16'h8000;
  localparam logic [COORD_BITS-1:0] COORD_MAX = 16'h7fff;
  localparam int SETTLE_CYCLES = 3 * DEPTH + 20;
  localparam int HOLD_CYCLES   = 400;
  // slowest run: every item giving DEPTH beats, each held by the longest stall
  localparam int unsigned CYCLE_LIMIT = 10_000_000;

  typedef struct packed {
    logic [STATUS_W-1:0]   st;
    logic                  pv;
    logic [COORD_BITS-1:0] px;
    logic [COORD_BITS-1:0] py;
    logic [CNT_W-1:0]      mc;
    logic [CNT_W-1:0]      occ;
    logic                  lf;
  } list_result_t;

  // mirror of the point list: same ordering, newest at index 0
  class point_list_mirror;
    logic signed [COORD_BITS-1:0] pts_x[DEPTH];
    logic signed [COORD_BITS-1:0] pts_y[DEPTH];
    int unsigned  held;
    list_result_t results_due[$];
    int unsigned  errors;

    function new();
      held   = 0;
      errors = 0;
    endfunction

    function void push_beat(logic [STATUS_W-1:0] st, logic pv, logic [COORD_BITS-1:0] px,
                            logic [COORD_BITS-1:0] py, logic [CNT_W-1:0] mc, logic lf);
      list_result_t r;
      r.st  = st;
      r.pv  = pv;
      r.px  = px;
      r.py  = py;
      r.mc  = mc;
      r.occ = held[CNT_W-1:0];
      r.lf  = lf;
      results_due.push_back(r);
    endfunction

    function bit inside_radius(int unsigned i, longint unsigned lim);
      longint sx;
      longint sy;
      longint unsigned ax;
      longint unsigned ay;
      sx = longint'(pts_x[i]);
      sy = longint'(pts_y[i]);
      ax = (sx < 0) ? -sx : sx;
      ay = (sy < 0) ? -sy : sy;
      return (ax * ax + ay * ay <= lim);
    endfunction

    // apply one accepted item to the mirror and queue the beats it causes
    function void run_list_op(logic [KIND_W-1:0] k, logic [COORD_BITS-1:0] x,
                              logic [COORD_BITS-1:0] y, logic [RADIUS_W-1:0] r);
      int unsigned i;
      int unsigned hits;
      int unsigned n;
      int found;
      longint unsigned rr;
      longint unsigned lim;
      found = -1;
      hits  = 0;
      n     = 0;
      rr    = 64'(r);
      lim   = rr * rr;
      case (k)
        KIND_INSERT: begin
          if (held >= DEPTH) begin
            push_beat(ST_FULL, 1'b0, '0, '0, '0, 1'b1);
          end else begin
            for (i = held; i > 0; i--) begin
              pts_x[i] = pts_x[i-1];
              pts_y[i] = pts_y[i-1];
            end
            pts_x[0] = x;
            pts_y[0] = y;
            held++;
            push_beat(ST_OK, 1'b0, '0, '0, '0, 1'b1);
          end
        end
        KIND_POP: begin
          if (held == 0) begin
            push_beat(ST_EMPTY, 1'b0, '0, '0, '0, 1'b1);
          end else begin
            for (i = 0; i + 1 < held; i++) begin
              pts_x[i] = pts_x[i+1];
              pts_y[i] = pts_y[i+1];
            end
            held--;
            push_beat(ST_OK, 1'b0, '0, '0, '0, 1'b1);
          end
        end
        KIND_REMOVE: begin
          if (held == 0) begin
            push_beat(ST_EMPTY, 1'b0, '0, '0, '0, 1'b1);
          end else begin
            for (i = 0; i < held; i++)
              if (found < 0 && pts_x[i] == x && pts_y[i] == y) found = i;
            if (found < 0) begin
              push_beat(ST_NOMATCH, 1'b0, '0, '0, '0, 1'b1);
            end else begin
              for (i = found; i + 1 < held; i++) begin
                pts_x[i] = pts_x[i+1];
                pts_y[i] = pts_y[i+1];
              end
              held--;
              push_beat(ST_OK, 1'b0, '0, '0, '0, 1'b1);
            end
          end
        end
        KIND_COUNT: begin
          for (i = 0; i < held; i++)
            if (pts_x[i] == x && pts_y[i] == y) hits++;
          push_beat(ST_OK, 1'b0, '0, '0, hits[CNT_W-1:0], 1'b1);
        end
        KIND_RANGE: begin
          if (held == 0) begin
            push_beat(ST_EMPTY, 1'b0, '0, '0, '0, 1'b1);
          end else begin
            for (i = 0; i < held; i++)
              if (inside_radius(i, lim)) hits++;
            if (hits == 0) begin
              push_beat(ST_NOMATCH, 1'b0, '0, '0, '0, 1'b1);
            end else begin
              for (i = 0; i < held; i++) begin
                if (inside_radius(i, lim)) begin
                  n++;
                  push_beat(ST_OK, 1'b1, pts_x[i], pts_y[i], '0, (n == hits));
                end
              end
            end
          end
        end
        default: begin
          push_beat(ST_OK, 1'b0, '0, '0, '0, 1'b1);
        end
      endcase
    endfunction

    function void check_result(list_result_t got);
      list_result_t want;
      bit bad;
      if (results_due.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result beat: status=%0d pv=%0b x=%0d y=%0d cnt=%0d occ=%0d last=%0b",
                   got.st, got.pv, $signed(got.px), $signed(got.py), got.mc, got.occ, got.lf);
        return;
      end
      want = results_due.pop_front();
      bad  = (got.st !== want.st) || (got.pv !== want.pv) || (got.px !== want.px) ||
             (got.py !== want.py) || (got.mc !== want.mc) || (got.occ !== want.occ) ||
             (got.lf !== want.lf);
      if (bad) begin
        errors++;
        if (errors <= 10) begin
          $display("result mismatch: want status=%0d pv=%0b x=%0d y=%0d cnt=%0d occ=%0d last=%0b",
                   want.st, want.pv, $signed(want.px), $signed(want.py), want.mc, want.occ,
                   want.lf);
          $display("                  got status=%0d pv=%0b x=%0d y=%0d cnt=%0d occ=%0d last=%0b",
                   got.st, got.pv, $signed(got.px), $signed(got.py), got.mc, got.occ, got.lf);
        end
      end
    endfunction
  endclass

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;
  always #1 clk = ~clk;

  // item channel, known from time zero
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [KIND_W-1:0]     kind     = '0;
  logic [COORD_BITS-1:0] x_coord  = '0;
  logic [COORD_BITS-1:0] y_coord  = '0;
  logic [RADIUS_W-1:0]   radius   = '0;

  // result channel
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [STATUS_W-1:0]   status;
  logic                  point_valid;
  logic [COORD_BITS-1:0] out_x;
  logic [COORD_BITS-1:0] out_y;
  logic [CNT_W-1:0]      match_count;
  logic [CNT_W-1:0]      occupancy;
  logic                  last;

  point_list_store_with_radius_query_top #(
    .DEPTH      (DEPTH),
    .COORD_BITS (COORD_BITS)
  ) DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .x_coord     (x_coord),
    .y_coord     (y_coord),
    .radius      (radius),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .point_valid (point_valid),
    .out_x       (out_x),
    .out_y       (out_y),
    .match_count (match_count),
    .occupancy   (occupancy),
    .last        (last)
  );

  point_list_mirror mirror = new();

  // when set, neither side idles
  bit quiet_mode = 1'b0;
  // main bumps this to ask the receiver for one long hold-off
  int unsigned hold_asks = 0;
  int unsigned hold_taken = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;

  // a few points reused often so that removes and counts hit
  logic [COORD_BITS-1:0] pool_x[8];
  logic [COORD_BITS-1:0] pool_y[8];

  // gap lengths: mostly none or short, a few long
  function automatic int unsigned gap_len();
    int unsigned r;
    if (quiet_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // receiver: check every result beat, then pick out_ready for the next edge
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready)
        mirror.check_result({status, point_valid, out_x, out_y, match_count, occupancy, last});
      if (hold_taken != hold_asks) begin
        hold_taken = hold_asks;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        // long hold-off: the block fills and stalls its item channel
        out_ready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_left = gap_len();
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // offer one item beat and hold it until taken, then note it in the mirror
  task automatic send_item(input logic [KIND_W-1:0] k, input logic [COORD_BITS-1:0] x,
                           input logic [COORD_BITS-1:0] y, input logic [RADIUS_W-1:0] r);
    int unsigned gap;
    kind     <= k;
    x_coord  <= x;
    y_coord  <= y;
    radius   <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    mirror.run_list_op(k, x, y, r);
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender pause until every queued result beat has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (mirror.results_due.size() != 0) @(posedge clk);
  endtask

  task automatic pick_point(output logic [COORD_BITS-1:0] x, output logic [COORD_BITS-1:0] y);
    int unsigned r;
    int unsigned idx;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      idx = $urandom_range(0, 7);
      x = pool_x[idx];
      y = pool_y[idx];
    end else if (r < 85) begin
      x = COORD_BITS'($urandom_range(0, 127) - 64);
      y = COORD_BITS'($urandom_range(0, 127) - 64);
    end else begin
      x = COORD_BITS'($urandom());
      y = COORD_BITS'($urandom());
    end
  endtask

  function automatic logic [RADIUS_W-1:0] pick_radius();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return RADIUS_W'($urandom_range(0, 100));
    if (r < 70) return RADIUS_W'($urandom_range(0, 2000));
    if (r < 85) return RADIUS_W'($urandom());
    if (r < 95) return RADIUS_MAX;
    return '0;
  endfunction

  // one stretch of random items; insert_pct sets whether the list grows or shrinks
  task automatic random_phase(input int unsigned n_items, input int unsigned insert_pct,
                              input bit want_hold);
    int unsigned i;
    int unsigned t;
    logic [KIND_W-1:0]     k;
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    for (i = 0; i < n_items; i++) begin
      if (want_hold && i == n_items / 2) hold_asks++;
      if ($urandom_range(0, 99) < insert_pct) begin
        k = KIND_INSERT;
      end else begin
        t = $urandom_range(0, 99);
        if (t < 20)      k = KIND_POP;
        else if (t < 45) k = KIND_REMOVE;
        else if (t < 65) k = KIND_COUNT;
        else if (t < 95) k = KIND_RANGE;
        else             k = KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI));
      end
      pick_point(x, y);
      send_item(k, x, y, pick_radius());
    end
  endtask

  initial begin
    int unsigned i;
    for (i = 0; i < 8; i++) begin
      pool_x[i] = COORD_BITS'($urandom_range(0, 40) - 20);
      pool_y[i] = COORD_BITS'($urandom_range(0, 40) - 20);
    end
    // one pool point at the coordinate extremes and one at the origin
    pool_x[6] = COORD_MIN;
    pool_y[6] = COORD_MAX;
    pool_x[7] = '0;
    pool_y[7] = '0;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty list: every operation but insert, and the spare kinds
    send_item(KIND_POP,    '0, '0, '0);
    send_item(KIND_REMOVE, '0, '0, '0);
    send_item(KIND_COUNT,  16'd5, 16'd5, '0);
    send_item(KIND_RANGE,  '0, '0, 15'd100);
    send_item(KIND_SPARE_LO,     '1, '1, RADIUS_MAX);
    send_item(KIND_W'(KIND_SPARE_LO + 1), '0, '0, '0);
    send_item(KIND_SPARE_HI,     COORD_MIN, COORD_MAX, RADIUS_MAX);
    // extremes and a duplicated point
    send_item(KIND_INSERT, COORD_MIN, COORD_MIN, '0);
    send_item(KIND_INSERT, COORD_MAX, COORD_MAX, '0);
    send_item(KIND_INSERT, '0, '0, '0);
    send_item(KIND_INSERT, COORD_MIN, COORD_MAX, '0);
    send_item(KIND_INSERT, 16'd3, 16'd4, '0);
    send_item(KIND_INSERT, 16'd3, 16'd4, '0);
    send_item(KIND_COUNT,  16'd3, 16'd4, '0);
    send_item(KIND_COUNT,  16'd1, 16'd1, '0);
    // several points inside, radius at both ends
    send_item(KIND_RANGE,  '0, '0, 15'd5);
    send_item(KIND_RANGE,  '0, '0, RADIUS_MAX);
    send_item(KIND_RANGE,  '0, '0, '0);
    // remove match at the tail, at the head, in the middle, and with no match
    send_item(KIND_REMOVE, COORD_MIN, COORD_MIN, '0);
    send_item(KIND_REMOVE, 16'd3, 16'd4, '0);
    send_item(KIND_REMOVE, '0, '0, '0);
    send_item(KIND_REMOVE, 16'd9, 16'd9, '0);
    // points stored but none inside the radius
    send_item(KIND_RANGE,  '0, '0, '0);
    send_item(KIND_POP,    '0, '0, '0);
    send_item(KIND_INSERT, COORD_MAX, COORD_MIN, '0);
    drain_results();

    random_phase(60, 50, 1'b0);
    // grow to full and keep pushing; receiver holds off once along the way
    random_phase(110, 85, 1'b1);
    drain_results();
    // a stretch with no idling on either side
    quiet_mode = 1'b1;
    random_phase(60, 20, 1'b0);
    quiet_mode = 1'b0;
    drain_results();
    // shrink back to empty
    random_phase(110, 15, 1'b0);
    drain_results();
    random_phase(95, 45, 1'b0);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mirror.errors == 0 && mirror.results_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
